// ===== hw/rtl/owrx_pkg.sv =====
// ----------------------------------------------------------------------------
// owrx_pkg
// Shared types and constants for the overwrite-oldest receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package owrx_pkg;

    // Request opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // Fixed field widths
    localparam int CAP_W  = 13;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 32;

    // Defaults
    localparam int              DEPTH_DEFAULT = 4096;
    localparam logic [CAP_W-1:0] CAP_RESET    = 13'd4096;

    // Input request
    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] rx_byte;
    } req_t;

    // Result
    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_ok;
        logic              dropped_oldest;
        logic [CAP_W-1:0]  fill_level;
        logic [CNT_W-1:0]  overrun_total;
        logic [CNT_W-1:0]  received_total;
    } rsp_t;

    // Result fields settled at issue, waiting for the memory read
    typedef struct packed {
        logic              rd;
        logic              dropped;
        logic [CAP_W-1:0]  fill;
        logic [CNT_W-1:0]  overrun;
        logic [CNT_W-1:0]  received;
    } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/owrx_ram.sv =====
// ----------------------------------------------------------------------------
// owrx_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module owrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/owrx_ctrl.sv =====
// ----------------------------------------------------------------------------
// owrx_ctrl
// Pointer, fill count and statistics update; issues the byte store access.
// ----------------------------------------------------------------------------
`default_nettype none

module owrx_ctrl #(
    parameter int DEPTH = owrx_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [owrx_pkg::CAP_W-1:0]       cfg_wdata,
    input  wire logic                             accept,
    input  wire owrx_pkg::req_t                   req,
    output logic                                  ram_we,
    output logic                                  ram_re,
    output logic      [$clog2(DEPTH)-1:0]         ram_addr,
    output logic      [owrx_pkg::BYTE_W-1:0]      ram_wdata,
    output owrx_pkg::stage_t                      stage
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = AW + 1;
    localparam int KW = (CW > owrx_pkg::CAP_W) ? CW : owrx_pkg::CAP_W;

    logic [owrx_pkg::CAP_W-1:0] capacity_reg;
    logic [AW-1:0]              wr_idx_reg, wr_idx_next;
    logic [AW-1:0]              rd_idx_reg, rd_idx_next;
    logic [CW-1:0]              held_reg, held_next;
    logic [owrx_pkg::CNT_W-1:0] ovr_reg, ovr_next;
    logic [owrx_pkg::CNT_W-1:0] rcv_reg, rcv_next;

    logic [KW-1:0] cap_ext;
    logic [KW-1:0] cap_lim;
    logic [NW-1:0] cap_n;
    logic [NW-1:0] wr_inc;
    logic [NW-1:0] rd_inc;
    logic [AW-1:0] wr_adv;
    logic [AW-1:0] rd_adv;
    logic          full;
    logic          nonempty;
    logic          is_push;
    logic          is_pop;

    // Clamp capacity to 1..DEPTH
    always_comb
    begin
        cap_ext = KW'(capacity_reg);
        if (cap_ext == '0)
        begin
            cap_lim = KW'(1);
        end
        else if (cap_ext > KW'(DEPTH))
        begin
            cap_lim = KW'(DEPTH);
        end
        else
        begin
            cap_lim = cap_ext;
        end
        cap_n = NW'(cap_lim);
    end

    // Advance pointers with wrap at the capacity
    assign wr_inc = {1'b0, wr_idx_reg} + NW'(1);
    assign rd_inc = {1'b0, rd_idx_reg} + NW'(1);
    assign wr_adv = (wr_inc >= cap_n) ? '0 : wr_inc[AW-1:0];
    assign rd_adv = (rd_inc >= cap_n) ? '0 : rd_inc[AW-1:0];

    assign full     = NW'(held_reg) >= cap_n;
    assign nonempty = held_reg != '0;
    assign is_push  = accept && (req.opcode == owrx_pkg::OP_PUSH);
    assign is_pop   = accept && (req.opcode == owrx_pkg::OP_POP) && nonempty;

    // Next state per request
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        held_next   = held_reg;
        ovr_next    = ovr_reg;
        rcv_next    = rcv_reg;
        if (accept)
        begin
            case (req.opcode)
                owrx_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        rd_idx_next = rd_adv;
                        ovr_next    = ovr_reg + 32'd1;
                    end
                    else
                    begin
                        held_next = held_reg + CW'(1);
                    end
                    wr_idx_next = wr_adv;
                    rcv_next    = rcv_reg + 32'd1;
                end
                owrx_pkg::OP_POP:
                begin
                    if (nonempty)
                    begin
                        rd_idx_next = rd_adv;
                        held_next   = held_reg - CW'(1);
                    end
                end
                owrx_pkg::OP_FLUSH:
                begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    held_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Store access: write on push, read on a pop that finds data
    assign ram_we    = is_push;
    assign ram_re    = is_pop;
    assign ram_addr  = is_push ? wr_idx_reg : rd_idx_reg;
    assign ram_wdata = req.rx_byte;

    // Result fields known at issue
    always_comb
    begin
        stage.rd       = is_pop;
        stage.dropped  = is_push && full;
        stage.fill     = owrx_pkg::CAP_W'(held_next);
        stage.overrun  = ovr_next;
        stage.received = rcv_next;
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= owrx_pkg::CAP_RESET;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            held_reg     <= '0;
            ovr_reg      <= '0;
            rcv_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            held_reg   <= held_next;
            ovr_reg    <= ovr_next;
            rcv_reg    <= rcv_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/owrx_out.sv =====
// ----------------------------------------------------------------------------
// owrx_out
// Read-wait stage and output register; joins store data to the result.
// ----------------------------------------------------------------------------
`default_nettype none

module owrx_out (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire owrx_pkg::stage_t            stage,
    input  wire logic [owrx_pkg::BYTE_W-1:0] rdata,
    output logic                             busy,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output owrx_pkg::rsp_t                   out_data
);

    logic             pend_valid_reg;
    owrx_pkg::stage_t pend_reg;
    logic             out_valid_reg;
    owrx_pkg::rsp_t   out_reg;
    logic             pend_adv;

    // Move the waiting request on when the output register frees up
    assign pend_adv = pend_valid_reg && (!out_valid_reg || !out_stall);
    assign busy     = pend_valid_reg && !pend_adv;

    // Track the waiting stage and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_adv)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= stage;
        end
        if (pend_adv)
        begin
            out_reg.read_byte      <= pend_reg.rd ? rdata : '0;
            out_reg.read_ok        <= pend_reg.rd;
            out_reg.dropped_oldest <= pend_reg.dropped;
            out_reg.fill_level     <= pend_reg.fill;
            out_reg.overrun_total  <= pend_reg.overrun;
            out_reg.received_total <= pend_reg.received;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/overwrite_oldest_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// overwrite_oldest_rx_fifo
// Byte receive FIFO that drops its oldest byte when a push finds it full.
// ----------------------------------------------------------------------------
// Takes one request per clock unless stalled (push, pop, flush or query) and
// returns one result for each, in order. A taken request waits in the
// read-wait stage for the registered RAM read, then its result moves into
// the output register when that is free. The byte store is a single-port
// synchronous RAM; pointers, the fill count and both wrapping totals update
// in the cycle the request is taken. One request waits for the RAM read
// while a finished result sits in the output register, so the input stalls
// only in a cycle in which the output is stalled while both of those hold a
// request; otherwise a request is taken every cycle. The capacity register
// (0 acts as 1, above DEPTH acts as DEPTH) should only be written while idle.
// No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_oldest_rx_fifo #(
    parameter int DEPTH = owrx_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [owrx_pkg::CAP_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire owrx_pkg::req_t             in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output owrx_pkg::rsp_t                  out_data
);

    localparam int AW = $clog2(DEPTH);

    logic                         accept;
    logic                         busy;
    logic                         ram_we;
    logic                         ram_re;
    logic [AW-1:0]                ram_addr;
    logic [owrx_pkg::BYTE_W-1:0]  ram_wdata;
    logic [owrx_pkg::BYTE_W-1:0]  ram_rdata;
    owrx_pkg::stage_t             stage;

    // Take a request whenever the read-wait stage can move
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    owrx_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .req       (in_data),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .stage     (stage)
    );

    owrx_ram #(
        .WIDTH (owrx_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    owrx_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .stage     (stage),
        .rdata     (ram_rdata),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/owrx_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// owrx_scoreboard_pkg
// Expected-result tracking for the overwrite-oldest receive FIFO testbench.
// The scoreboard keeps its own copy of the byte store, both pointers, the fill
// count, both wrapping totals and the capacity. It derives one expected result
// per accepted request and compares results field by field, in order.
// ----------------------------------------------------------------------------
package owrx_scoreboard_pkg;

    import owrx_pkg::*;

    localparam int SLOTS = DEPTH_DEFAULT;
    localparam int PTR_W = $clog2(SLOTS);

    class rx_fifo_scoreboard;
        logic [BYTE_W-1:0] byte_store [SLOTS];
        bit                slot_written [SLOTS];
        bit [PTR_W-1:0]    wr_ptr;
        bit [PTR_W-1:0]    rd_ptr;
        bit [CAP_W-1:0]    held;
        bit [CAP_W-1:0]    cap_reg;
        bit [CNT_W-1:0]    overruns;
        bit [CNT_W-1:0]    pushes;
        rsp_t              expected_rsp_q [$];
        int                errors;
        int                checked;
        int                empty_pops;
        int                op_count [4];

        function new();
            cap_reg = CAP_RESET;
        endfunction

        function void set_capacity(bit [CAP_W-1:0] value);
            cap_reg = value;
        endfunction

        // Clamp the register: zero acts as one, anything above the store as the store
        function bit [CAP_W-1:0] live_cap();
            if (cap_reg == 0)
                return CAP_W'(1);
            if (cap_reg > SLOTS)
                return CAP_W'(SLOTS);
            return cap_reg;
        endfunction

        // Advance a pointer, wrapping at the capacity
        function bit [PTR_W-1:0] step_ptr(bit [PTR_W-1:0] ptr, bit [CAP_W-1:0] cap);
            bit [CAP_W-1:0] nxt;
            nxt = CAP_W'(ptr) + 1'b1;
            return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
        endfunction

        // True when a pop now would not hit a slot that no push ever filled
        function bit pop_reads_written();
            return (held == 0) || slot_written[rd_ptr];
        endfunction

        function int pending();
            return expected_rsp_q.size();
        endfunction

        // Update the FIFO image for one accepted request and queue its result
        function void note_request(req_t req);
            rsp_t           exp_rsp;
            bit [CAP_W-1:0] cap;
            exp_rsp = '0;
            cap     = live_cap();
            op_count[req.opcode]++;
            case (req.opcode)
                OP_PUSH:
                begin
                    // Drop the oldest byte when full
                    if (held >= cap)
                    begin
                        rd_ptr = step_ptr(rd_ptr, cap);
                        held--;
                        exp_rsp.dropped_oldest = 1'b1;
                        overruns++;
                    end
                    byte_store[wr_ptr]   = req.rx_byte;
                    slot_written[wr_ptr] = 1'b1;
                    wr_ptr = step_ptr(wr_ptr, cap);
                    held++;
                    pushes++;
                end
                OP_POP:
                begin
                    if (held != 0)
                    begin
                        exp_rsp.read_byte = byte_store[rd_ptr];
                        exp_rsp.read_ok   = 1'b1;
                        rd_ptr = step_ptr(rd_ptr, cap);
                        held--;
                    end
                    else
                        empty_pops++;
                end
                OP_FLUSH:
                begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                    held   = '0;
                end
                default: ;
            endcase
            exp_rsp.fill_level     = held;
            exp_rsp.overrun_total  = overruns;
            exp_rsp.received_total = pushes;
            expected_rsp_q.push_back(exp_rsp);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(rsp_t got);
            rsp_t exp_rsp;
            checked++;
            if (expected_rsp_q.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", got);
                errors++;
                return;
            end
            exp_rsp = expected_rsp_q.pop_front();
            if (got.read_byte !== exp_rsp.read_byte)
            begin
                $error("read_byte: expected %0d, got %0d", exp_rsp.read_byte, got.read_byte);
                errors++;
            end
            if (got.read_ok !== exp_rsp.read_ok)
            begin
                $error("read_ok: expected %0d, got %0d", exp_rsp.read_ok, got.read_ok);
                errors++;
            end
            if (got.dropped_oldest !== exp_rsp.dropped_oldest)
            begin
                $error("dropped_oldest: expected %0d, got %0d",
                       exp_rsp.dropped_oldest, got.dropped_oldest);
                errors++;
            end
            if (got.fill_level !== exp_rsp.fill_level)
            begin
                $error("fill_level: expected %0d, got %0d", exp_rsp.fill_level, got.fill_level);
                errors++;
            end
            if (got.overrun_total !== exp_rsp.overrun_total)
            begin
                $error("overrun_total: expected %0d, got %0d",
                       exp_rsp.overrun_total, got.overrun_total);
                errors++;
            end
            if (got.received_total !== exp_rsp.received_total)
            begin
                $error("received_total: expected %0d, got %0d",
                       exp_rsp.received_total, got.received_total);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_overwrite_oldest_rx_fifo.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overwrite_oldest_rx_fifo
// Self-checking testbench for the overwrite-oldest receive FIFO.
// A short directed run covers empty pops, flush, query, byte extremes,
// overwrite on full and capacity changes with bytes held, including the
// clamped settings 0 and 8191. Random phases follow at many capacities, one
// of them pushing a 200-byte FIFO well past full so the write pointer wraps,
// with random idling on both sides, a long output hold-off and drains between
// phases.
// ----------------------------------------------------------------------------
module tb_overwrite_oldest_rx_fifo;

    import owrx_pkg::*;
    import owrx_scoreboard_pkg::*;

    localparam int IDLE_PCT  = 20;
    localparam int LONG_HOLD = 64;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CAP_W-1:0]   cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    req_t               in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rsp_t               out_data;

    rx_fifo_scoreboard  sb;
    bit                 calm;
    bit                 long_hold_req;
    int                 long_holds;
    int                 stalled_in_cycles;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    overwrite_oldest_rx_fifo u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(out_data);
    end

    // Count cycles with a request held back by the block
    always @(posedge clk)
    begin
        if (in_valid && in_stall === 1'b1)
            stalled_in_cycles++;
    end

    // Stall the output at random, or hold it off for a long stretch on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_holds++;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Offer one request and hold it until the block takes it
    task automatic send_req(input logic [1:0] op, input logic [BYTE_W-1:0] data_byte,
                            input bit may_idle);
        req_t req;
        // Never pop a slot that no push has filled; flush instead
        if (op == OP_POP && !sb.pop_reads_written())
            op = OP_FLUSH;
        req.opcode  = op;
        req.rx_byte = data_byte;
        @(negedge clk);
        while (may_idle && !calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(req);
    endtask

    // Stop offering and wait until every outstanding result is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_capacity(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain, set the capacity, then send a random request mix
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items,
                             input int push_pct, input int pop_pct, input int flush_pct,
                             input int hold_at);
        int         pick;
        int         burst;
        logic [1:0] op;
        drain();
        write_capacity(cap);
        burst = 0;
        for (int i = 0; i < n_items; i++)
        begin
            // Keep offering back to back while the output is held off
            if (i == hold_at)
            begin
                long_hold_req = 1'b1;
                burst = LONG_HOLD + 16;
            end
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                op = OP_PUSH;
            else if (pick < push_pct + pop_pct)
                op = OP_POP;
            else if (pick < push_pct + pop_pct + flush_pct)
                op = OP_FLUSH;
            else
                op = OP_QUERY;
            send_req(op, BYTE_W'($urandom), burst == 0);
            if (burst > 0)
                burst--;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty pop, query, byte extremes, pops and flush at reset capacity
        send_req(OP_POP, 8'h00, 1'b1);
        send_req(OP_QUERY, 8'hFF, 1'b1);
        send_req(OP_PUSH, 8'h00, 1'b1);
        send_req(OP_PUSH, 8'hFF, 1'b1);
        send_req(OP_PUSH, 8'h55, 1'b1);
        send_req(OP_PUSH, 8'hAA, 1'b1);
        send_req(OP_QUERY, 8'h00, 1'b1);
        send_req(OP_POP, 8'hFF, 1'b1);
        send_req(OP_POP, 8'h00, 1'b1);
        send_req(OP_FLUSH, 8'h5A, 1'b1);
        send_req(OP_POP, 8'h00, 1'b1);

        // Zero capacity acts as one: overwrite on the second push
        drain();
        write_capacity('0);
        send_req(OP_PUSH, 8'h12, 1'b1);
        send_req(OP_PUSH, 8'h34, 1'b1);
        send_req(OP_POP, 8'h00, 1'b1);
        send_req(OP_POP, 8'h00, 1'b1);
        send_req(OP_PUSH, 8'h9C, 1'b1);

        // Change capacity with a byte held
        drain();
        write_capacity(13'd2);
        send_req(OP_PUSH, 8'h63, 1'b1);
        send_req(OP_PUSH, 8'hC3, 1'b1);
        send_req(OP_POP, 8'h00, 1'b1);
        send_req(OP_POP, 8'h00, 1'b1);

        // Capacity above the store acts as the full store
        drain();
        write_capacity(13'h1FFF);
        send_req(OP_PUSH, 8'h7E, 1'b1);
        send_req(OP_POP, 8'h00, 1'b1);

        // Random phases; no flush between them, so bytes stay held across changes
        run_phase(13'd1, 60, 50, 35, 3, -1);
        run_phase(13'd2, 80, 50, 35, 3, -1);
        run_phase(13'd3, 80, 55, 30, 3, -1);
        run_phase('0, 50, 50, 35, 3, -1);
        run_phase(13'h1FFF, 50, 50, 35, 3, -1);
        calm = 1'b1;
        run_phase(13'd5, 100, 60, 25, 3, -1);
        calm = 1'b0;
        run_phase(13'd16, 120, 60, 30, 2, 40);
        run_phase(13'($urandom_range(6, 64)), 80, 55, 35, 3, -1);
        run_phase(13'd7, 70, 45, 45, 4, -1);
        // Push well past full so the write pointer wraps and pushes overwrite
        run_phase(13'd200, 240, 96, 2, 0, -1);
        run_phase(13'd4, 50, 40, 50, 2, -1);
        run_phase(13'd4095, 60, 50, 40, 3, -1);

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d requests: %0d push, %0d pop (%0d on empty), %0d flush, %0d query",
                 sb.op_count[OP_PUSH] + sb.op_count[OP_POP] + sb.op_count[OP_FLUSH]
                 + sb.op_count[OP_QUERY], sb.op_count[OP_PUSH], sb.op_count[OP_POP],
                 sb.empty_pops, sb.op_count[OP_FLUSH], sb.op_count[OP_QUERY]);
        $display("Checked %0d results, %0d overwriting pushes, %0d long holds, %0d input stalls",
                 sb.checked, sb.overruns, long_holds, stalled_in_cycles);
        if (sb.errors == 0)
            $display("tb_overwrite_oldest_rx_fifo: PASS");
        else
            $display("tb_overwrite_oldest_rx_fifo: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding", sb.pending());
        $display("tb_overwrite_oldest_rx_fifo: FAIL");
        $finish;
    end

endmodule
